[hw/rtl/adsig_pkg.sv]
// Shared types and constants for the asymmetric double sigmoid shaper.
// No dependencies; every other file imports this package.
`default_nettype none

package adsig_pkg;

   // Per-stage control: common advance enable and the stage's valid bit
   typedef struct packed {
      logic en;
      logic valid;
   } adsig_ctl_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_GAIN      = 2'd0,
      CSR_MAX_LEVEL = 2'd1,
      CSR_DC_OFFSET = 2'd2,
      CSR_CUTOFF    = 2'd3
   } csr_index_type;

   // Register reset values
   localparam logic [15:0] GAIN_RST      = 16'd5120;  // 20.0 in Q8.8
   localparam logic [14:0] MAX_LEVEL_RST = 15'd9830;  // 0.3 in Q0.15
   localparam logic [15:0] DC_OFFSET_RST = 16'd0;
   localparam logic [15:0] CUTOFF_RST    = 16'd1638;  // 0.05 in Q1.15

   // Internal fixed-point format and root normalization limit
   localparam int INT_FRAC  = 16;
   localparam int NORM_BITS = 46;

endpackage

`default_nettype wire

[hw/rtl/adsig_sqrt_cell.sv]
// One cell of the square-root chain: resolves one root bit per cycle while its advance enable is set.
// Depends on adsig_pkg.
`default_nettype none

module adsig_sqrt_cell
   import adsig_pkg::*;
#(
   parameter int RW = 31,
   parameter int VW = 62,
   parameter int I  = 0,
   parameter int XW = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire adsig_ctl_type     ctl_in,
   input  wire logic [VW-1:0]     v_in,
   input  wire logic [RW+1:0]     rem_in,
   input  wire logic [RW-1:0]     root_in,
   input  wire logic [XW-1:0]     side_in,
   output logic                   valid_out,
   output logic      [VW-1:0]     v_out,
   output logic      [RW+1:0]     rem_out,
   output logic      [RW-1:0]     root_out,
   output logic      [XW-1:0]     side_out
);

   logic          valid_ff;
   logic [VW-1:0] v_ff;
   logic [RW+1:0] rem_ff, rem_in_c, rem_sh, trial;
   logic [RW-1:0] root_ff, root_in_c;
   logic [XW-1:0] side_ff;
   logic          take;

   // bring down the next bit pair and try (root << 2) | 1
   always_comb begin
      rem_sh    = {rem_in[RW-1:0], v_in[2*I+1:2*I]};
      trial     = {root_in, 2'b01};
      take      = (rem_sh >= trial);
      rem_in_c  = take ? (rem_sh - trial) : rem_sh;
      root_in_c = {root_in[RW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl_in.en) begin
         valid_ff <= ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.en) begin
         v_ff    <= v_in;
         rem_ff  <= rem_in_c;
         root_ff <= root_in_c;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign v_out     = v_ff;
   assign rem_out   = rem_ff;
   assign root_out  = root_ff;
   assign side_out  = side_ff;

endmodule

`default_nettype wire

[hw/rtl/adsig_div_cell.sv]
// One cell of the restoring divider chain: resolves one quotient bit per cycle while its advance enable is set.
// Depends on adsig_pkg.
`default_nettype none

module adsig_div_cell
   import adsig_pkg::*;
#(
   parameter int DW = 31,
   parameter int NW = 42,
   parameter int QW = 26,
   parameter int I  = 0,
   parameter int XW = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire adsig_ctl_type     ctl_in,
   input  wire logic [NW-1:0]     n_in,
   input  wire logic [DW-1:0]     den_in,
   input  wire logic [DW-1:0]     rem_in,
   input  wire logic [QW-1:0]     q_in,
   input  wire logic [XW-1:0]     side_in,
   output logic                   valid_out,
   output logic      [NW-1:0]     n_out,
   output logic      [DW-1:0]     den_out,
   output logic      [DW-1:0]     rem_out,
   output logic      [QW-1:0]     q_out,
   output logic      [XW-1:0]     side_out
);

   logic          valid_ff;
   logic [NW-1:0] n_ff;
   logic [DW-1:0] den_ff, rem_ff, rem_in_c;
   logic [QW-1:0] q_ff, q_in_c;
   logic [XW-1:0] side_ff;
   logic [DW:0]   rem_sh, diff;
   logic          take;

   // shift in the next numerator bit, subtract when it fits
   always_comb begin
      rem_sh   = {rem_in, n_in[I]};
      diff     = rem_sh - {1'b0, den_in};
      take     = (rem_sh >= {1'b0, den_in});
      rem_in_c = take ? diff[DW-1:0] : rem_sh[DW-1:0];
      q_in_c   = {q_in[QW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl_in.en) begin
         valid_ff <= ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.en) begin
         n_ff    <= n_in;
         den_ff  <= den_in;
         rem_ff  <= rem_in_c;
         q_ff    <= q_in_c;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign n_out     = n_ff;
   assign den_out   = den_ff;
   assign rem_out   = rem_ff;
   assign q_out     = q_ff;
   assign side_out  = side_ff;

endmodule

`default_nettype wire

[hw/rtl/adsig_pass.sv]
// One sigmoid pass m*g*x/sqrt(1+g*(g*x)^2)+dc as a pipeline of cells.
// Depends on adsig_pkg, adsig_sqrt_cell and adsig_div_cell.
`default_nettype none

module adsig_pass
   import adsig_pkg::*;
#(
   parameter int SW  = 16,
   parameter int GF  = 8,
   parameter int TGW = 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire logic signed [SW-1:0]  x,
   input  wire logic [TGW-1:0]        tag_in,
   input  wire logic [16:0]           g,
   input  wire logic [14:0]           m,
   input  wire logic signed [15:0]    dc,
   output logic                       out_valid,
   output logic signed [SW-1:0]       y,
   output logic [TGW-1:0]             tag_out
);

   localparam int S     = SW - 1;
   localparam int AW    = 17;
   localparam int GW    = 17;
   localparam int UW    = GW + AW - GF;
   localparam int SQW   = 2 * UW - INT_FRAC;
   localparam int L     = SQW / 2;
   localparam int PW    = GW + SQW;
   localparam int WW    = PW - GF;
   localparam int QW    = WW + 1;
   localparam int MW    = (QW > NORM_BITS) ? NORM_BITS : QW;
   localparam int EMAX  = (QW > NORM_BITS) ? ((QW - NORM_BITS + 1) / 2) * 2 : 0;
   localparam int EHMAX = EMAX / 2;
   localparam int EHW   = (EHMAX > 0) ? $clog2(EHMAX + 1) : 1;
   localparam int RW    = (MW + INT_FRAC + 1) / 2;
   localparam int VW    = 2 * RW;
   localparam int DW    = RW + EHMAX;
   localparam int NW    = UW + INT_FRAC;
   localparam int QTW   = UW;
   localparam int RPW   = UW + 15;
   localparam int SH    = 31 - S;
   localparam int RRW   = RPW - SH;
   localparam int TW    = ((RRW > SW) ? RRW : SW) + 3;
   localparam int XS    = TGW + 1 + UW + EHW;
   localparam int XD    = TGW + 1;

   // ---------------- stage A: magnitude to Q.16
   logic [SW-1:0]  mag;
   logic [AW-1:0]  a_in, a_ff;
   logic           neg_a_ff, valid_a_ff;
   logic [TGW-1:0] tag_a_ff;
   logic signed [SW-1:0] dc_s;

   assign mag = x[SW-1] ? SW'(-x) : SW'(x);

   generate
      if (S >= 16) begin : g_a_down
         assign a_in = AW'(mag >> (S - 16));
      end else begin : g_a_up
         assign a_in = AW'({mag, {(16 - S){1'b0}}});
      end
      if (S >= 15) begin : g_dc_up
         assign dc_s = SW'(dc) <<< (S - 15);
      end else begin : g_dc_down
         assign dc_s = SW'(dc >>> (15 - S));
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff     <= a_in;
         neg_a_ff <= x[SW-1];
         tag_a_ff <= tag_in;
      end
   end

   // ---------------- stage B: u = g*a
   logic [GW+AW-1:0] prod_b;
   logic [UW-1:0]    u_b_ff;
   logic             neg_b_ff, valid_b_ff;
   logic [TGW-1:0]   tag_b_ff;

   assign prod_b = (GW+AW)'(g) * (GW+AW)'(a_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         u_b_ff   <= prod_b[GW+AW-1:GF];
         neg_b_ff <= neg_a_ff;
         tag_b_ff <= tag_a_ff;
      end
   end

   // ---------------- stage C: sq = u*u
   logic [2*UW-1:0] prod_c;
   logic [SQW-1:0]  sq_c_ff;
   logic [UW-1:0]   u_c_ff;
   logic            neg_c_ff, valid_c_ff;
   logic [TGW-1:0]  tag_c_ff;

   assign prod_c = (2*UW)'(u_b_ff) * (2*UW)'(u_b_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         sq_c_ff  <= prod_c[2*UW-1:INT_FRAC];
         u_c_ff   <= u_b_ff;
         neg_c_ff <= neg_b_ff;
         tag_c_ff <= tag_b_ff;
      end
   end

   // ---------------- stage D: g*sq as two partial products
   logic [GW+L-1:0]     pl_in, pl_d_ff;
   logic [GW+SQW-L-1:0] ph_in, ph_d_ff;
   logic [UW-1:0]       u_d_ff;
   logic                neg_d_ff, valid_d_ff;
   logic [TGW-1:0]      tag_d_ff;

   assign pl_in = (GW+L)'(g) * (GW+L)'(sq_c_ff[L-1:0]);
   assign ph_in = (GW+SQW-L)'(g) * (GW+SQW-L)'(sq_c_ff[SQW-1:L]);

   always_ff @(posedge clock) begin
      if (en) begin
         pl_d_ff  <= pl_in;
         ph_d_ff  <= ph_in;
         u_d_ff   <= u_c_ff;
         neg_d_ff <= neg_c_ff;
         tag_d_ff <= tag_c_ff;
      end
   end

   // ---------------- stage E: q = 1 + g*(g*x)^2
   logic [PW-1:0]  wsum;
   logic [QW-1:0]  q_in, q_e_ff;
   logic [UW-1:0]  u_e_ff;
   logic           neg_e_ff, valid_e_ff;
   logic [TGW-1:0] tag_e_ff;

   assign wsum = (PW'(ph_d_ff) << L) + PW'(pl_d_ff);
   assign q_in = QW'(wsum[PW-1:GF]) + (QW'(1) << INT_FRAC);

   always_ff @(posedge clock) begin
      if (en) begin
         q_e_ff   <= q_in;
         u_e_ff   <= u_d_ff;
         neg_e_ff <= neg_d_ff;
         tag_e_ff <= tag_d_ff;
      end
   end

   // ---------------- stage F: normalize q below 2^46 by an even shift
   logic [EHW-1:0] eh_in, eh_f_ff;
   logic [QW-1:0]  qs;
   logic [VW-1:0]  v_in, v_f_ff;
   logic [UW-1:0]  u_f_ff;
   logic           neg_f_ff, valid_f_ff;
   logic [TGW-1:0] tag_f_ff;

   always_comb begin
      eh_in = EHW'(EHMAX);
      for (int k = EHMAX; k >= 0; k--) begin
         if (((q_e_ff >> (2 * k)) >> NORM_BITS) == '0) begin
            eh_in = EHW'(k);
         end
      end
      qs   = q_e_ff >> {eh_in, 1'b0};
      v_in = VW'({qs[MW-1:0], {INT_FRAC{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         eh_f_ff  <= eh_in;
         v_f_ff   <= v_in;
         u_f_ff   <= u_e_ff;
         neg_f_ff <= neg_e_ff;
         tag_f_ff <= tag_e_ff;
      end
   end

   // ---------------- square-root chain, one root bit per cell
   logic [RW:0]   s_valid;
   logic [VW-1:0] s_v    [RW+1];
   logic [RW+1:0] s_rem  [RW+1];
   logic [RW-1:0] s_root [RW+1];
   logic [XS-1:0] s_side [RW+1];

   assign s_valid[0] = valid_f_ff;
   assign s_v[0]     = v_f_ff;
   assign s_rem[0]   = '0;
   assign s_root[0]  = '0;
   assign s_side[0]  = {tag_f_ff, neg_f_ff, u_f_ff, eh_f_ff};

   generate
      for (genvar j = 0; j < RW; j++) begin : g_sqrt
         adsig_sqrt_cell #(
            .RW (RW),
            .VW (VW),
            .I  (RW - 1 - j),
            .XW (XS)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl_in    ('{en: en, valid: s_valid[j]}),
            .v_in      (s_v[j]),
            .rem_in    (s_rem[j]),
            .root_in   (s_root[j]),
            .side_in   (s_side[j]),
            .valid_out (s_valid[j+1]),
            .v_out     (s_v[j+1]),
            .rem_out   (s_rem[j+1]),
            .root_out  (s_root[j+1]),
            .side_out  (s_side[j+1])
         );
      end
   endgenerate

   // ---------------- stage G: den = root << (e/2)
   logic [EHW-1:0] eh_g;
   logic [UW-1:0]  u_g;
   logic [DW-1:0]  den_g_ff;
   logic [NW-1:0]  n_g_ff;
   logic           neg_g_ff, valid_g_ff;
   logic [TGW-1:0] tag_g_ff;

   assign eh_g = s_side[RW][EHW-1:0];
   assign u_g  = s_side[RW][EHW+UW-1:EHW];

   always_ff @(posedge clock) begin
      if (en) begin
         den_g_ff <= DW'(s_root[RW]) << eh_g;
         n_g_ff   <= {u_g, {INT_FRAC{1'b0}}};
         neg_g_ff <= s_side[RW][EHW+UW];
         tag_g_ff <= s_side[RW][XS-1:EHW+UW+1];
      end
   end

   // ---------------- divider chain, one quotient bit per cell
   logic [QTW:0]   d_valid;
   logic [NW-1:0]  d_n    [QTW+1];
   logic [DW-1:0]  d_den  [QTW+1];
   logic [DW-1:0]  d_rem  [QTW+1];
   logic [QTW-1:0] d_q    [QTW+1];
   logic [XD-1:0]  d_side [QTW+1];

   assign d_valid[0] = valid_g_ff;
   assign d_n[0]     = n_g_ff;
   assign d_den[0]   = den_g_ff;
   assign d_rem[0]   = DW'(n_g_ff[NW-1:QTW]);
   assign d_q[0]     = '0;
   assign d_side[0]  = {tag_g_ff, neg_g_ff};

   generate
      for (genvar j = 0; j < QTW; j++) begin : g_div
         adsig_div_cell #(
            .DW (DW),
            .NW (NW),
            .QW (QTW),
            .I  (QTW - 1 - j),
            .XW (XD)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl_in    ('{en: en, valid: d_valid[j]}),
            .n_in      (d_n[j]),
            .den_in    (d_den[j]),
            .rem_in    (d_rem[j]),
            .q_in      (d_q[j]),
            .side_in   (d_side[j]),
            .valid_out (d_valid[j+1]),
            .n_out     (d_n[j+1]),
            .den_out   (d_den[j+1]),
            .rem_out   (d_rem[j+1]),
            .q_out     (d_q[j+1]),
            .side_out  (d_side[j+1])
         );
      end
   endgenerate

   // ---------------- stage H: scale by max level
   logic [RPW-1:0] prod_h;
   logic [RRW-1:0] r_h_ff;
   logic           neg_h_ff, valid_h_ff;
   logic [TGW-1:0] tag_h_ff;

   assign prod_h = RPW'(d_q[QTW]) * RPW'(m);

   always_ff @(posedge clock) begin
      if (en) begin
         r_h_ff   <= prod_h[RPW-1:SH];
         neg_h_ff <= d_side[QTW][0];
         tag_h_ff <= d_side[QTW][XD-1:1];
      end
   end

   // ---------------- stage I: sign, offset and saturate
   logic [TW-1:0]        r_ext;
   logic signed [TW-1:0] rv, dv, sum, hi_lim, lo_lim;
   logic signed [SW-1:0] y_in, y_ff;
   logic                 valid_i_ff;
   logic [TGW-1:0]       tag_i_ff;

   always_comb begin
      r_ext  = TW'(r_h_ff);
      rv     = neg_h_ff ? signed'(-r_ext) : signed'(r_ext);
      dv     = TW'(dc_s);
      sum    = rv + dv;
      hi_lim = signed'((TW'(1) << S) - TW'(1));
      lo_lim = ~hi_lim;
      if (sum > hi_lim) begin
         y_in = SW'(hi_lim);
      end else if (sum < lo_lim) begin
         y_in = SW'(lo_lim);
      end else begin
         y_in = SW'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff     <= y_in;
         tag_i_ff <= tag_h_ff;
      end
   end

   // ---------------- valid bits of the explicit stages
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
         valid_e_ff <= 1'b0;
         valid_f_ff <= 1'b0;
         valid_g_ff <= 1'b0;
         valid_h_ff <= 1'b0;
         valid_i_ff <= 1'b0;
      end else if (en) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
         valid_d_ff <= valid_c_ff;
         valid_e_ff <= valid_d_ff;
         valid_f_ff <= valid_e_ff;
         valid_g_ff <= s_valid[RW];
         valid_h_ff <= d_valid[QTW];
         valid_i_ff <= valid_h_ff;
      end
   end

   assign out_valid = valid_i_ff;
   assign y         = y_ff;
   assign tag_out   = tag_i_ff;

endmodule

`default_nettype wire

[hw/rtl/asymmetric_double_sigmoid_shaper.sv]
// Asymmetric double sigmoid shaper, top level: config registers, cutoff
// compare, two sigmoid passes in series and the output register.
// Widths: RW = root bits, UW = 34-GAIN_FRAC_BITS. One item per cycle is sustained
// while the output is not backed up.
// The square-root and divider cell chains set the depth of each pass.
// Synchronous active-high reset clears valid bits and loads register defaults.
`default_nettype none

module asymmetric_double_sigmoid_shaper
   import adsig_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]     rsp_sample_out,
   input  wire logic                          csr_wr_en,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [15:0]                   csr_wdata
);

   localparam int SW = SAMPLE_WIDTH;
   localparam int S  = SW - 1;

   // ---------------- configuration registers
   logic [15:0]        gain_ff;
   logic [14:0]        max_level_ff;
   logic signed [15:0] dc_offset_ff;
   logic signed [15:0] cutoff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_RST;
         max_level_ff <= MAX_LEVEL_RST;
         dc_offset_ff <= DC_OFFSET_RST;
         cutoff_ff    <= CUTOFF_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN:      gain_ff      <= csr_wdata;
            CSR_MAX_LEVEL: max_level_ff <= csr_wdata[14:0];
            CSR_DC_OFFSET: dc_offset_ff <= csr_wdata;
            CSR_CUTOFF:    cutoff_ff    <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // ---------------- pipeline advance: stall only with a full tail and a full output that rsp_ready does not take
   logic en, p1_valid, p2_valid, rsp_valid_ff;
   logic signed [SW-1:0] y1, y2, rsp_sample_ff;
   logic [0:0]           tag1;
   logic [SW:0]          tag2;

   assign en        = !p2_valid || !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // ---------------- cutoff compare at full precision
   logic signed [SW+14:0] lhs, rhs;
   logic                  above;

   assign lhs   = {req_sample_in, 15'b0};
   assign rhs   = {cutoff_ff, {S{1'b0}}};
   assign above = (lhs > rhs);

   // ---------------- first pass with gain
   adsig_pass #(
      .SW  (SW),
      .GF  (GAIN_FRAC_BITS),
      .TGW (1)
   ) u_pass1 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .x         (req_sample_in),
      .tag_in    (above),
      .g         ({1'b0, gain_ff}),
      .m         (max_level_ff),
      .dc        (dc_offset_ff),
      .out_valid (p1_valid),
      .y         (y1),
      .tag_out   (tag1)
   );

   // ---------------- second pass with twice the gain
   adsig_pass #(
      .SW  (SW),
      .GF  (GAIN_FRAC_BITS),
      .TGW (SW + 1)
   ) u_pass2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p1_valid),
      .x         (y1),
      .tag_in    ({tag1, y1}),
      .g         ({gain_ff, 1'b0}),
      .m         (max_level_ff),
      .dc        (dc_offset_ff),
      .out_valid (p2_valid),
      .y         (y2),
      .tag_out   (tag2)
   );

   // ---------------- output register
   logic                 rsp_valid_in;
   logic signed [SW-1:0] rsp_sample_in;

   always_comb begin
      rsp_sample_in = tag2[SW] ? y2 : signed'(tag2[SW-1:0]);
      if (en && p2_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && p2_valid) begin
         rsp_sample_ff <= rsp_sample_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for asymmetric_double_sigmoid_shaper: directed table,
// random samples over several register settings, compared against a predictor.
// Depends on adsig_pkg and the shaper RTL only.
`timescale 1ns / 1ps

module testbench
   import adsig_pkg::*;
();

   localparam int LAT = 133;

   typedef struct {
      logic signed [15:0] sample;
      bit                 known;
      logic signed [15:0] result;
   } dir_row_type;

   typedef struct {
      logic [15:0] gain;
      logic [15:0] level;
      logic [15:0] dc;
      logic [15:0] cut;
   } setting_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_sample_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_sample_out;
   logic csr_wr_en = 1'b0;
   csr_index_type csr_index = CSR_GAIN;
   logic [15:0] csr_wdata = '0;

   // Predictor copy of the registers
   logic [15:0]        p_gain = GAIN_RST;
   logic [14:0]        p_level = MAX_LEVEL_RST;
   logic signed [15:0] p_dc = DC_OFFSET_RST;
   logic signed [15:0] p_cut = CUTOFF_RST;

   logic signed [15:0] shaped_q[$];
   int errors = 0;
   int rsp_seen = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   asymmetric_double_sigmoid_shaper dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_sample_out(rsp_sample_out),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // One sigmoid pass: odd curve on the magnitude, then dc and saturation
   function automatic longint sigmoid(longint xs, longint unsigned g);
      longint unsigned mag, a, u, sq, w, q, den, ratio, r;
      longint v;
      int e;
      mag = (xs < 0) ? longint'(-xs) : longint'(xs);
      a = mag << 1;
      u = (g * a) >> 8;
      sq = (u * u) >> 16;
      w = (g * sq) >> 8;
      q = (64'd1 << 16) + w;
      e = 0;
      while ((q >> e) >= (64'd1 << 46)) e += 2;
      den = int_sqrt((q >> e) << 16) << (e / 2);
      ratio = (u << 16) / den;
      r = (ratio * longint'(p_level)) >> 16;
      v = ((xs < 0) ? -longint'(r) : longint'(r)) + longint'(p_dc);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   function automatic logic signed [15:0] shape(logic signed [15:0] x);
      longint y;
      y = sigmoid(longint'(x), longint'(p_gain));
      if (x > p_cut) y = sigmoid(y, longint'(p_gain) * 2);
      return y[15:0];
   endfunction

   task automatic write_reg(csr_index_type idx, logic [15:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_GAIN:      p_gain = data;
         CSR_MAX_LEVEL: p_level = data[14:0];
         CSR_DC_OFFSET: p_dc = data;
         CSR_CUTOFF:    p_cut = data;
         default:       ;
      endcase
   endtask

   task automatic idle_gap();
      int n;
      n = $urandom_range(99);
      if (n < 65) n = 0;
      else if (n < 95) n = $urandom_range(3, 1);
      else n = $urandom_range(40, 10);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Offer one item and hold it until accepted; the expectation is queued then
   task automatic send(logic signed [15:0] x, bit known, logic signed [15:0] res);
      req_valid <= 1'b1;
      req_sample_in <= x;
      do @(posedge clock); while (!req_ready);
      shaped_q.push_back(known ? res : shape(x));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (shaped_q.size() != 0) @(posedge clock);
      repeat (LAT + 10) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_sample();
      int k;
      k = $urandom_range(9);
      case (k)
         0: return 16'(16'sh7FFF - $urandom_range(3));
         1: return 16'(16'sh8000 + $urandom_range(3));
         2: return 16'($urandom_range(255) - 128);
         3: return 16'(p_cut + $urandom_range(4) - 2);
         4: return 16'($urandom_range(4095) - 2048);
         default: return 16'($urandom);
      endcase
   endfunction

   // Result side: random stalls, one long hold-off to back up the pipeline
   always @(posedge clock) begin
      int stall;
      if (rsp_valid && rsp_ready) begin
         if (shaped_q.size() == 0) begin
            $display("%0t: unexpected result %0d", $time, rsp_sample_out);
            errors++;
         end else begin
            if (rsp_sample_out !== shaped_q[0]) begin
               $display("%0t: sample_out expected %0d actual %0d",
                        $time, shaped_q[0], rsp_sample_out);
               errors++;
            end
            void'(shaped_q.pop_front());
         end
         rsp_seen++;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_seen == 400 && rsp_valid && rsp_ready) begin
         rsp_ready <= 1'b0;
         stall = 500;
         repeat (stall) @(posedge clock);
      end else begin
         stall = $urandom_range(99);
         if (stall == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(40, 10)) @(posedge clock);
         end else begin
            rsp_ready <= (stall >= 25);
         end
      end
   end

   initial begin
      dir_row_type dir_rows[$];
      setting_type settings[$];
      setting_type s;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: defaults, zero, extremes and the samples around the cutoff
      dir_rows = '{
         '{16'sd0, 1'b1, 16'sd0},
         '{16'sh7FFF, 1'b0, 16'sd0}, '{16'sh8000, 1'b0, 16'sd0},
         '{16'sh7FFE, 1'b0, 16'sd0}, '{16'sh8001, 1'b0, 16'sd0},
         '{16'sd1, 1'b0, 16'sd0}, '{-16'sd1, 1'b0, 16'sd0},
         '{16'sd1637, 1'b0, 16'sd0}, '{16'sd1638, 1'b0, 16'sd0},
         '{16'sd1639, 1'b0, 16'sd0}, '{-16'sd1638, 1'b0, 16'sd0},
         '{16'sh5555, 1'b0, 16'sd0}, '{16'shAAAA, 1'b0, 16'sd0},
         '{16'sd256, 1'b0, 16'sd0}, '{-16'sd256, 1'b0, 16'sd0}};
      foreach (dir_rows[i]) send(dir_rows[i].sample, dir_rows[i].known, dir_rows[i].result);
      drain();

      // Zero gain leaves only the saturated offset
      write_reg(CSR_GAIN, 16'd0);
      write_reg(CSR_DC_OFFSET, 16'h7FFF);
      send(16'sh8000, 1'b1, 16'sh7FFF);
      send(16'sh7FFF, 1'b1, 16'sh7FFF);
      drain();
      write_reg(CSR_DC_OFFSET, 16'h8000);
      send(16'sh7FFF, 1'b1, 16'sh8000);
      drain();

      settings = '{
         '{16'd5120, 16'd9830, 16'h0000, 16'd1638},
         '{16'hFFFF, 16'hFFFF, 16'h0000, 16'd1638},
         '{16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000},
         '{16'd1, 16'h7FFF, 16'h8000, 16'h7FFF},
         '{16'd256, 16'h4000, 16'h1234, 16'h0000},
         '{16'd0, 16'h1000, 16'hF000, 16'h8000},
         '{16'd64, 16'h7FFF, 16'h0000, 16'hFF00},
         '{16'd40000, 16'd20000, 16'hE000, 16'h0100},
         '{16'd0, 16'd0, 16'd0, 16'd0},
         '{16'd0, 16'd0, 16'd0, 16'd0}};
      foreach (settings[i]) begin
         s = settings[i];
         if (i >= 8) s = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
         write_reg(CSR_GAIN, s.gain);
         write_reg(CSR_MAX_LEVEL, s.level);
         write_reg(CSR_DC_OFFSET, s.dc);
         write_reg(CSR_CUTOFF, s.cut);
         repeat (150) begin
            idle_gap();
            send(rand_sample(), 1'b0, 16'sd0);
         end
         drain();
      end

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
